### hw/rtl/tga_rle_pkg.sv
// shared types and constants for the tga run-length pixel decoder
package tga_rle_pkg;

    // result status codes
    localparam logic [2:0] STAT_PIXEL    = 3'd0;
    localparam logic [2:0] STAT_HDR_OK   = 3'd1;
    localparam logic [2:0] STAT_BAD_SIG  = 3'd2;
    localparam logic [2:0] STAT_BAD_HDR  = 3'd3;
    localparam logic [2:0] STAT_OVERFLOW = 3'd4;

    // file signature and header layout
    localparam int unsigned SIG_LEN = 12;
    localparam int unsigned HDR_LEN = 6;
    localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
        8'd0, 8'd0, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };
    localparam logic [7:0] BPP_24 = 8'd24;
    localparam logic [7:0] BPP_32 = 8'd32;

    // header byte positions
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd0;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd1;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd2;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd3;
    localparam logic [4:0] HDR_BPP       = 5'd4;
    localparam logic [4:0] HDR_LAST      = 5'(HDR_LEN - 1);
    localparam logic [4:0] SIG_LAST      = 5'(SIG_LEN - 1);

    // one result word
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_count;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        has_alpha;
        logic        image_done;
    } result_t;

endpackage

### hw/rtl/tga_rle_pixel_decoder.sv
// top level of the tga run-length pixel decoder
//
// Usage: the input channel (in_valid, in_stall, in_byte, file_start) takes the
// compressed file one byte per word; file_start marks signature byte 0 of a new
// file and restarts the parse. The output channel (out_valid, out_stall and the
// result fields) gives at most one word per input byte: a header verdict, a
// signature error, or one pixel color with its repeat count.
// Output: a result is registered into the output register, or into the skid
// slot while the front word waits, as the byte that causes it is accepted.
// Throughput: one byte per cycle while in_stall is low, set by the parser
// step (16x16 pixel-total multiply, 32-bit remaining subtract and compare).
// Reset: the parser returns to waiting for the signature and both output slots
// are emptied.
// Stall: results sit in an output register backed by one skid slot; bytes keep
// being accepted while a result waits, and in_stall rises only once the skid
// slot holds a second result. It drops in the cycle after the receiver takes
// the front word.
module tga_rle_pixel_decoder
    import tga_rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        file_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic [7:0]  repeat_count,
    output logic [15:0] image_width,
    output logic [15:0] image_height,
    output logic        has_alpha,
    output logic        image_done
);

    typedef enum logic [2:0] {
        PH_SIG,
        PH_HDR,
        PH_HDR_BAD,
        PH_PKT,
        PH_PIX,
        PH_DONE,
        PH_ERR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  hdr_idx_reg, hdr_idx_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic        four_reg, four_next;
    logic [31:0] remain_reg, remain_next;
    logic [7:0]  left_reg, left_next;
    logic        is_run_reg, is_run_next;
    logic [1:0]  cidx_reg, cidx_next;
    logic [31:0] color_reg, color_next;

    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_data_reg, skid_data_next;

    // state seen by this byte, with file_start applied first
    phase_t      cur_phase;
    logic [4:0]  cur_hdr_idx;
    logic [15:0] cur_width;
    logic [15:0] cur_height;
    logic        cur_four;
    logic [31:0] cur_remain;
    logic [7:0]  cur_left;
    logic        cur_is_run;
    logic [1:0]  cur_cidx;
    logic [31:0] cur_color;

    logic        in_accept;
    logic        out_take;
    logic        res_valid;
    result_t     res;
    logic [31:0] pixel_total;
    logic [1:0]  last_cidx;
    logic [7:0]  rep;
    logic [2:0]  pix_status;
    logic [31:0] remain_after;
    logic [7:0]  left_after;

    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;

    assign pixel_total = 32'(width_reg) * 32'(height_reg);

    // restart view
    always_comb
    begin
        if (file_start)
        begin
            cur_phase   = PH_SIG;
            cur_hdr_idx = '0;
            cur_width   = '0;
            cur_height  = '0;
            cur_four    = 1'b0;
            cur_remain  = '0;
            cur_left    = '0;
            cur_is_run  = 1'b0;
            cur_cidx    = '0;
            cur_color   = '0;
        end
        else
        begin
            cur_phase   = phase_reg;
            cur_hdr_idx = hdr_idx_reg;
            cur_width   = width_reg;
            cur_height  = height_reg;
            cur_four    = four_reg;
            cur_remain  = remain_reg;
            cur_left    = left_reg;
            cur_is_run  = is_run_reg;
            cur_cidx    = cidx_reg;
            cur_color   = color_reg;
        end
    end

    // parser step for one accepted byte
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        four_next    = four_reg;
        remain_next  = remain_reg;
        left_next    = left_reg;
        is_run_next  = is_run_reg;
        cidx_next    = cidx_reg;
        color_next   = color_reg;
        res_valid    = 1'b0;
        res          = '0;
        last_cidx    = four_reg ? 2'd3 : 2'd2;
        rep          = '0;
        pix_status   = STAT_PIXEL;
        remain_after = remain_reg;
        left_after   = left_reg;

        if (in_accept)
        begin
            phase_next   = cur_phase;
            hdr_idx_next = cur_hdr_idx;
            width_next   = cur_width;
            height_next  = cur_height;
            four_next    = cur_four;
            remain_next  = cur_remain;
            left_next    = cur_left;
            is_run_next  = cur_is_run;
            cidx_next    = cur_cidx;
            color_next   = cur_color;
            last_cidx    = cur_four ? 2'd3 : 2'd2;

            case (cur_phase)
                PH_SIG:
                begin
                    if (in_byte != SIG_BYTES[cur_hdr_idx[3:0]])
                    begin
                        phase_next = PH_ERR;
                        res_valid  = 1'b1;
                        res.status = STAT_BAD_SIG;
                    end
                    else if (cur_hdr_idx == SIG_LAST)
                    begin
                        hdr_idx_next = '0;
                        phase_next   = PH_HDR;
                    end
                    else
                    begin
                        hdr_idx_next = cur_hdr_idx + 5'd1;
                    end
                end

                PH_HDR, PH_HDR_BAD:
                begin
                    case (cur_hdr_idx)
                        HDR_WIDTH_LO:  width_next[7:0]   = in_byte;
                        HDR_WIDTH_HI:  width_next[15:8]  = in_byte;
                        HDR_HEIGHT_LO: height_next[7:0]  = in_byte;
                        HDR_HEIGHT_HI: height_next[15:8] = in_byte;
                        HDR_BPP:
                        begin
                            four_next = (in_byte == BPP_32);
                            if (in_byte != BPP_24 && in_byte != BPP_32)
                            begin
                                phase_next = PH_HDR_BAD;
                            end
                        end
                        default: ;
                    endcase
                    if (cur_hdr_idx == HDR_LAST)
                    begin
                        // header complete: width and height already registered
                        hdr_idx_next     = '0;
                        res_valid        = 1'b1;
                        res.image_width  = cur_width;
                        res.image_height = cur_height;
                        res.has_alpha    = cur_four;
                        if (cur_phase == PH_HDR_BAD || cur_width == '0 || cur_height == '0)
                        begin
                            phase_next = PH_ERR;
                            res.status = STAT_BAD_HDR;
                        end
                        else
                        begin
                            remain_next = pixel_total;
                            phase_next  = PH_PKT;
                            res.status  = STAT_HDR_OK;
                        end
                    end
                    else
                    begin
                        hdr_idx_next = cur_hdr_idx + 5'd1;
                    end
                end

                PH_PKT:
                begin
                    if (!in_byte[7])
                    begin
                        left_next   = in_byte + 8'd1;
                        is_run_next = 1'b0;
                    end
                    else
                    begin
                        left_next   = in_byte - 8'd127;
                        is_run_next = 1'b1;
                    end
                    cidx_next  = '0;
                    color_next = '0;
                    phase_next = PH_PIX;
                end

                PH_PIX:
                begin
                    case (cur_cidx)
                        2'd0:    color_next[7:0]   = in_byte;
                        2'd1:    color_next[15:8]  = in_byte;
                        2'd2:    color_next[23:16] = in_byte;
                        default: color_next[31:24] = in_byte;
                    endcase
                    if (cur_cidx < last_cidx)
                    begin
                        cidx_next = cur_cidx + 2'd1;
                    end
                    else
                    begin
                        cidx_next = '0;
                        if (cur_is_run)
                        begin
                            // run clipped to the pixels left in the image
                            if (32'(cur_left) > cur_remain)
                            begin
                                rep        = cur_remain[7:0];
                                pix_status = STAT_OVERFLOW;
                            end
                            else
                            begin
                                rep = cur_left;
                            end
                            remain_after = cur_remain - 32'(rep);
                            left_after   = '0;
                        end
                        else
                        begin
                            rep          = 8'd1;
                            remain_after = cur_remain - 32'd1;
                            left_after   = cur_left - 8'd1;
                            if (remain_after == '0 && cur_left > 8'd1)
                            begin
                                pix_status = STAT_OVERFLOW;
                            end
                        end
                        remain_next = remain_after;
                        left_next   = left_after;
                        if (remain_after == '0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (left_after == '0)
                        begin
                            phase_next = PH_PKT;
                        end
                        res_valid        = 1'b1;
                        res.status       = pix_status;
                        res.blue         = color_next[7:0];
                        res.green        = color_next[15:8];
                        res.red          = color_next[23:16];
                        res.alpha        = cur_four ? color_next[31:24] : 8'd0;
                        res.repeat_count = rep;
                        res.image_width  = cur_width;
                        res.image_height = cur_height;
                        res.has_alpha    = cur_four;
                        res.image_done   = (remain_after == '0);
                    end
                end

                default: ;
            endcase
        end
    end

    // output register with one skid slot
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_accept && res_valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // parser state and output slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIG;
            hdr_idx_reg    <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            four_reg       <= 1'b0;
            remain_reg     <= '0;
            left_reg       <= '0;
            is_run_reg     <= 1'b0;
            cidx_reg       <= '0;
            color_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            skid_valid_reg <= 1'b0;
            skid_data_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hdr_idx_reg    <= hdr_idx_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            four_reg       <= four_next;
            remain_reg     <= remain_next;
            left_reg       <= left_next;
            is_run_reg     <= is_run_next;
            cidx_reg       <= cidx_next;
            color_reg      <= color_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            skid_valid_reg <= skid_valid_next;
            skid_data_reg  <= skid_data_next;
        end
    end

    // result ports
    assign out_valid    = out_valid_reg;
    assign status       = out_data_reg.status;
    assign red          = out_data_reg.red;
    assign green        = out_data_reg.green;
    assign blue         = out_data_reg.blue;
    assign alpha        = out_data_reg.alpha;
    assign repeat_count = out_data_reg.repeat_count;
    assign image_width  = out_data_reg.image_width;
    assign image_height = out_data_reg.image_height;
    assign has_alpha    = out_data_reg.has_alpha;
    assign image_done   = out_data_reg.image_done;

endmodule

### hw/rtl/tga_rle_checker.sv
// port-level assertions for the tga run-length pixel decoder, with bind
module tga_rle_checker
    import tga_rle_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic [7:0]  alpha,
    input logic [7:0]  repeat_count,
    input logic [15:0] image_width,
    input logic [15:0] image_height,
    input logic        has_alpha,
    input logic        image_done
);

    // held word keeps its contents while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(red)
            && $stable(repeat_count) && $stable(image_done))
        else $error("result word changed under stall");

    // input can only stall while a word waits at the output
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // signature error word carries nothing but its status
    a_bad_sig_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_BAD_SIG |-> red == '0 && green == '0 && blue == '0
            && alpha == '0 && repeat_count == '0 && image_width == '0
            && image_height == '0 && !has_alpha && !image_done)
        else $error("bad signature word has stray fields");

    // end of image only on a pixel word with a nonzero count
    a_done_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_done |-> (status == STAT_PIXEL || status == STAT_OVERFLOW)
            && repeat_count != '0)
        else $error("image done on a non-pixel word");

    // pixel words never carry alpha for 24-bit images, nor a zero count
    a_pixel_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_PIXEL || status == STAT_OVERFLOW)
            |-> repeat_count != '0 && (has_alpha || alpha == '0))
        else $error("bad pixel word fields");

endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_tga_rle_checker (.*);
